/* design/min_heap_priority_queue_macros.svh */
// ----------------------------------------------------------------------------
// Min-heap priority queue assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Check a property at every clock edge outside reset.
`define HPQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define HPQ_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

/* design/hpq_pkg.sv */
// ----------------------------------------------------------------------------
// hpq_pkg
// Types, codes and helpers shared by the min-heap priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hpq_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 11;
  // Heap index width, enough for the largest supported depth (1-based).
  localparam int IDX_W   = 17;
  localparam int LVL_W   = 5;

  typedef enum logic {
    KIND_INSERT  = 1'b0,
    KIND_EXTRACT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_FETCH,
    S_TAKE,
    S_RUN,
    S_RESULT
  } state_e;

  typedef struct packed {
    kind_e                    kind;
    logic signed [KEY_W-1:0]  key;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]  min_value;
    status_e                  status;
    logic [COUNT_W-1:0]       count;
  } out_item_t;

  // Two sibling nodes share one memory word; odd index sits in hi.
  typedef struct packed {
    logic [KEY_W-1:0] hi;
    logic [KEY_W-1:0] lo;
  } pair_t;

  // Operation travelling down the level chain.
  typedef struct packed {
    logic              valid;
    kind_e             op;
    logic [KEY_W-1:0]  key;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  path;
    logic [LVL_W-1:0]  rem;
    logic [IDX_W-1:0]  bound;
  } tok_t;

  // Read request into one level memory.
  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  idx;
  } req_t;

  function automatic logic key_less(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic logic [LVL_W-1:0] msb_pos(logic [IDX_W-1:0] v);
    logic [LVL_W-1:0] pos;
    pos = '0;
    for (int b = 0; b < IDX_W; b++) begin
      if (v[b]) begin
        pos = LVL_W'(b);
      end
    end
    return pos;
  endfunction

endpackage

/* design/hpq_ram.sv */
// ----------------------------------------------------------------------------
// hpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/hpq_cell.sv */
// ----------------------------------------------------------------------------
// hpq_cell
// One heap level: its node memory plus the compare-and-forward step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpq_cell #(
  parameter int LEVEL = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hpq_pkg::tok_t   tok_i,
  output hpq_pkg::tok_t   tok_o,
  input  hpq_pkg::req_t   req_i,
  output hpq_pkg::req_t   req_o,
  input  hpq_pkg::req_t   fetch_i,
  input  hpq_pkg::pair_t  child_rd_i,
  output hpq_pkg::pair_t  rd_o,
  output logic            done_o
);

  import hpq_pkg::*;

  localparam int PD = (LEVEL == 0) ? 1 : (1 << (LEVEL - 1));
  localparam int AW = (PD > 1) ? $clog2(PD) : 1;

  tok_t             tok_q;
  pair_t            rd_pair;
  pair_t            wr_pair;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             wr_en;
  logic             fetch_hit;
  logic [KEY_W-1:0] own_val;
  logic [KEY_W-1:0] wr_val;
  logic [IDX_W:0]   left_idx;
  logic [IDX_W:0]   right_idx;
  logic             left_ok;
  logic             right_ok;
  logic             pick_right;
  logic [KEY_W-1:0] pick_val;
  logic             move;
  logic             last;
  logic             swap;

  // Hold the arriving operation for its decide cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_i;
    end
  end

  assign fetch_hit = fetch_i.valid &&
                     ((LEVEL == 0) || ((fetch_i.idx >> LEVEL) == IDX_W'(1)));

  always_comb begin
    rd_en   = tok_i.valid || req_i.valid || fetch_hit;
    rd_addr = '0;
    if (PD > 1) begin
      priority if (tok_i.valid) begin
        rd_addr = tok_i.idx[AW:1];
      end else if (req_i.valid) begin
        rd_addr = req_i.idx[AW-1:0];
      end else begin
        rd_addr = fetch_i.idx[AW:1];
      end
    end
  end

  // Extract needs the children pair from the next level.
  assign req_o.valid = tok_i.valid && (tok_i.op == KIND_EXTRACT);
  assign req_o.idx   = tok_i.idx;

  assign own_val   = tok_q.idx[0] ? rd_pair.hi : rd_pair.lo;
  assign left_idx  = {tok_q.idx, 1'b0};
  assign right_idx = {tok_q.idx, 1'b1};
  assign left_ok   = left_idx <= {1'b0, tok_q.bound};
  assign right_ok  = right_idx <= {1'b0, tok_q.bound};
  assign pick_right = right_ok && key_less(child_rd_i.hi, child_rd_i.lo);
  assign pick_val  = pick_right ? child_rd_i.hi : child_rd_i.lo;
  assign move      = left_ok && key_less(pick_val, tok_q.key);
  assign last      = (tok_q.rem == '0);
  assign swap      = key_less(tok_q.key, own_val);

  always_comb begin
    tok_o  = '0;
    wr_en  = 1'b0;
    wr_val = tok_q.key;
    done_o = 1'b0;
    if (tok_q.valid) begin
      unique case (tok_q.op)
        KIND_EXTRACT: begin
          // Promote the smaller child, or settle the moving key here.
          wr_en       = 1'b1;
          wr_val      = move ? pick_val : tok_q.key;
          done_o      = !move;
          tok_o.valid = move;
          tok_o.op    = KIND_EXTRACT;
          tok_o.key   = tok_q.key;
          tok_o.idx   = pick_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
          tok_o.bound = tok_q.bound;
        end
        KIND_INSERT: begin
          if (last) begin
            // Fill the free slot at the end of the heap.
            wr_en  = 1'b1;
            done_o = 1'b1;
          end else begin
            wr_en       = swap;
            tok_o.valid = 1'b1;
            tok_o.op    = KIND_INSERT;
            tok_o.key   = swap ? own_val : tok_q.key;
            tok_o.idx   = {tok_q.idx[IDX_W-2:0], tok_q.path[IDX_W-1]};
            tok_o.path  = {tok_q.path[IDX_W-2:0], 1'b0};
            tok_o.rem   = tok_q.rem - LVL_W'(1);
          end
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  assign wr_pair = tok_q.idx[0] ? {wr_val, rd_pair.lo} : {rd_pair.hi, wr_val};
  assign wr_addr = (PD > 1) ? tok_q.idx[AW:1] : '0;

  hpq_ram #(
    .WIDTH ($bits(pair_t)),
    .DEPTH (PD)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_pair),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_pair)
  );

  assign rd_o = rd_pair;

endmodule

/* design/min_heap_priority_queue.sv */
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// Binary min-heap priority queue of signed keys, one memory per heap level.
// ----------------------------------------------------------------------------
// The heap is a chain of level cells, each owning the memory for one tree
// level, so every operation walks top-down one level per clock cycle. One
// operation is in flight at a time. An insert walks from the root to the
// new slot at depth L, at most ceil(log2(DEPTH + 1)) - 1 (10 for the default
// depth of 1024); an extract first reads the root and the last entry
// (S_FETCH, then S_TAKE) and then sinks the moved key down L levels.
// The one-level-per-cycle pace is set by the registered read of each level
// memory. The next item is taken while a finished result still waits on the
// output register. Reset clears the count and the control state but not the
// level memories: no memory clearing pass is needed. Every transfer gives
// exactly one result with status and the count after the operation; an
// extract from an empty heap or an insert into a full heap leaves the heap
// untouched and reports its status with a zero min_value.
`timescale 1ns / 1ps

`include "min_heap_priority_queue_macros.svh"

module min_heap_priority_queue #(
  parameter int DEPTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  hpq_pkg::in_item_t     in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output hpq_pkg::out_item_t    out_data_o
);

  import hpq_pkg::*;

  // Count width, which is also the number of levels in the chain.
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int LEVELS = CW;

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q;
  logic [KEY_W-1:0] key_q;
  logic [KEY_W-1:0] res_min_q;
  status_e          res_status_q;

  logic             in_xfer;
  logic             heap_full;
  logic             heap_empty;
  logic             out_load;
  logic             take_min;

  tok_t             tok [LEVELS+1];
  req_t             req [LEVELS+1];
  pair_t            rd  [LEVELS+1];
  logic [LEVELS-1:0] done_vec;
  logic             done_any;
  req_t             fetch;

  logic [IDX_W-1:0] tail_idx;
  logic [LVL_W-1:0] tail_lvl;
  logic [IDX_W-1:0] tail_path;
  logic [IDX_W-1:0] last_idx;
  pair_t            last_pair;
  logic [KEY_W-1:0] last_key;
  logic [KEY_W-1:0] root_key;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign heap_full  = (count_q == CW'(DEPTH));
  assign heap_empty = (count_q == '0);
  assign done_any   = |done_vec;

  // Insert path: the new slot index, its level, and the branch bits below
  // its top bit, left-aligned so each level peels off the next one.
  assign tail_idx  = IDX_W'(count_q);
  assign tail_lvl  = msb_pos(tail_idx);
  assign tail_path = tail_idx << (LVL_W'(IDX_W) - tail_lvl);

  // Extract: the old last entry sits one past the shrunk count.
  assign last_idx = IDX_W'(count_q) + IDX_W'(1);

  always_comb begin
    last_pair = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if ((last_idx >> l) == IDX_W'(1)) begin
        last_pair = rd[l];
      end
    end
  end

  assign last_key = last_idx[0] ? last_pair.hi : last_pair.lo;
  assign root_key = rd[0].hi;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          priority if (in_data_i.kind == KIND_INSERT && !heap_full) begin
            state_d = S_INS;
          end else if (in_data_i.kind == KIND_EXTRACT && !heap_empty) begin
            state_d = S_FETCH;
          end else begin
            state_d = S_RESULT;
          end
        end
      end
      S_INS:    state_d = S_RUN;
      S_FETCH:  state_d = S_TAKE;
      S_TAKE:   state_d = heap_empty ? S_RESULT : S_RUN;
      S_RUN:    state_d = done_any ? S_RESULT : S_RUN;
      S_RESULT: state_d = (!out_valid_q || !out_stall_i) ? S_IDLE : S_RESULT;
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    tok[0]     = '0;
    fetch      = '0;
    take_min   = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_INS: begin
        // Launch the insert at the root with the path to the new slot.
        tok[0].valid = 1'b1;
        tok[0].op    = KIND_INSERT;
        tok[0].key   = key_q;
        tok[0].idx   = IDX_W'(1);
        tok[0].path  = tail_path;
        tok[0].rem   = tail_lvl;
      end
      S_FETCH: begin
        // Read the root and the old last entry in one go.
        fetch.valid = 1'b1;
        fetch.idx   = last_idx;
      end
      S_TAKE: begin
        take_min = 1'b1;
        if (!heap_empty) begin
          // Put the last entry at the root and sink it.
          tok[0].valid = 1'b1;
          tok[0].op    = KIND_EXTRACT;
          tok[0].key   = last_key;
          tok[0].idx   = IDX_W'(1);
          tok[0].bound = IDX_W'(count_q);
        end
      end
      S_RESULT: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (in_xfer) begin
      priority if (in_data_i.kind == KIND_INSERT && !heap_full) begin
        count_d = count_q + CW'(1);
      end else if (in_data_i.kind == KIND_EXTRACT && !heap_empty) begin
        count_d = count_q - CW'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      key_q     <= in_data_i.key;
      res_min_q <= '0;
      priority if (in_data_i.kind == KIND_INSERT && heap_full) begin
        res_status_q <= ST_FULL;
      end else if (in_data_i.kind == KIND_EXTRACT && heap_empty) begin
        res_status_q <= ST_EMPTY;
      end else begin
        res_status_q <= ST_OK;
      end
    end
    if (take_min) begin
      res_min_q <= root_key;
    end
    if (out_load) begin
      out_q.min_value <= res_min_q;
      out_q.status    <= res_status_q;
      out_q.count     <= COUNT_W'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Level chain: each cell hands its operation and child read to the next.
  assign req[0]      = '0;
  assign rd[LEVELS]  = '0;

  for (genvar l = 0; l < LEVELS; l++) begin : g_level
    hpq_cell #(
      .LEVEL (l)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tok_i      (tok[l]),
      .tok_o      (tok[l+1]),
      .req_i      (req[l]),
      .req_o      (req[l+1]),
      .fetch_i    (fetch),
      .child_rd_i (rd[l+1]),
      .rd_o       (rd[l]),
      .done_o     (done_vec[l])
    );
  end

  // An operation must finish inside the chain.
  `HPQ_NEVER(a_no_overrun, tok[LEVELS].valid || req[LEVELS].valid,
             "operation ran past the bottom level")

  // Only one level finishes an operation.
  `HPQ_ASSERT(a_one_done, $onehot0(done_vec), "more than one level finished")

  // Levels finish only while an operation is running.
  `HPQ_ASSERT(a_done_in_run, done_any |-> state_q == S_RUN,
              "level finished outside a running operation")

  // The count stays within the capacity.
  `HPQ_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "count above capacity")

endmodule

/* sim/heap_result_checker.sv */
// ----------------------------------------------------------------------------
// heap_result_checker
// Watches both channels of the min-heap priority queue, keeps its own heap
// of the accepted keys, and compares each result with the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module heap_result_checker #(
  parameter int HEAP_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  hpq_pkg::in_item_t   in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  hpq_pkg::out_item_t  out_data_i,
  output int                  error_count_o,
  output int                  outstanding_o
);

  logic signed [hpq_pkg::KEY_W-1:0] heap_keys [HEAP_DEPTH];
  int                               heap_size;
  hpq_pkg::out_item_t               predicted_out [$];

  // Apply one operation to the shadow heap and return the result it gives.
  function automatic hpq_pkg::out_item_t heap_apply(hpq_pkg::in_item_t op);
    hpq_pkg::out_item_t               res;
    logic signed [hpq_pkg::KEY_W-1:0] tmp;
    int                               pos;
    int                               up;
    int                               kid;
    res.min_value = '0;
    res.status    = hpq_pkg::ST_OK;
    if (op.kind == hpq_pkg::KIND_INSERT) begin
      if (heap_size >= HEAP_DEPTH) begin
        res.status = hpq_pkg::ST_FULL;
      end else begin
        pos = heap_size;
        heap_keys[pos] = op.key;
        heap_size++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!(heap_keys[pos] < heap_keys[up])) break;
          tmp = heap_keys[pos];
          heap_keys[pos] = heap_keys[up];
          heap_keys[up] = tmp;
          pos = up;
        end
      end
    end else begin
      if (heap_size == 0) begin
        res.status = hpq_pkg::ST_EMPTY;
      end else begin
        res.min_value = heap_keys[0];
        heap_size--;
        heap_keys[0] = heap_keys[heap_size];
        pos = 0;
        // Sink toward the smaller child; the left one wins a tie.
        while (2 * pos + 1 < heap_size) begin
          kid = 2 * pos + 1;
          if (kid + 1 < heap_size && heap_keys[kid + 1] < heap_keys[kid]) kid++;
          if (!(heap_keys[kid] < heap_keys[pos])) break;
          tmp = heap_keys[pos];
          heap_keys[pos] = heap_keys[kid];
          heap_keys[kid] = tmp;
          pos = kid;
        end
      end
    end
    res.count = hpq_pkg::COUNT_W'(heap_size);
    return res;
  endfunction

  task automatic flag_field(input string what, input logic [31:0] want,
                            input logic [31:0] got);
    error_count_o++;
    $display("%t heap check: %s expected %0h actual %0h", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin
    hpq_pkg::out_item_t want;
    if (!rst_ni) begin
      heap_size     = 0;
      error_count_o = 0;
      outstanding_o = 0;
      predicted_out.delete();
    end else begin
      // Check the result first: it always belongs to an earlier transfer.
      if (out_valid_i && !out_stall_i) begin
        if (predicted_out.size() == 0) begin
          error_count_o++;
          $display("%t heap check: unexpected result expected none actual %0h",
                   $time, out_data_i);
        end else begin
          want = predicted_out.pop_front();
          if (out_data_i.min_value !== want.min_value) begin
            flag_field("min_value", want.min_value, out_data_i.min_value);
          end
          if (out_data_i.status !== want.status) begin
            flag_field("status", 32'(want.status), 32'(out_data_i.status));
          end
          if (out_data_i.count !== want.count) begin
            flag_field("count", 32'(want.count), 32'(out_data_i.count));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predicted_out.push_back(heap_apply(in_data_i));
      end
      outstanding_o = predicted_out.size();
    end
  end

endmodule

/* sim/min_heap_priority_queue_tb.sv */
// ----------------------------------------------------------------------------
// min_heap_priority_queue_tb
// Drives insert and extract transfers into the heap queue and gives the
// verdict. Directed corner items come first, then random segments with
// shifting insert/extract mix, then a full drain.
// Both channels idle at random; the checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_heap_priority_queue_tb;

  localparam int HEAP_DEPTH  = 1024;
  // Hold the result side long enough that the block backs up into its input.
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AFTER  = 200;
  // Watch a while after the drain for any stray result.
  localparam int TAIL_CYCLES = 24;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  hpq_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  hpq_pkg::out_item_t out_data;

  int error_count;
  int outstanding;
  int sent_count = 0;
  int fill_level = 0;

  min_heap_priority_queue #(
    .DEPTH(HEAP_DEPTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  heap_result_checker #(
    .HEAP_DEPTH(HEAP_DEPTH)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .error_count_o(error_count),
    .outstanding_o(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bound the run well beyond the slowest legal schedule.
  initial begin
    #15_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int draw_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Mix extremes, a narrow band that forces equal keys, and full-range keys.
  function automatic logic [31:0] draw_key();
    logic [31:0] k;
    case ($urandom_range(0, 9))
      0:       k = 32'h7fff_ffff;
      1:       k = 32'h8000_0000;
      2, 3, 4: k = 32'(int'($urandom_range(0, 16)) - 8);
      5:       k = {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
      default: k = $urandom();
    endcase
    return k;
  endfunction

  // Offer one transfer and hold it until the block takes it.
  task automatic push_op(input hpq_pkg::kind_e kind, input logic [31:0] key);
    in_data  <= '{kind: kind, key: key};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent_count++;
    if (kind == hpq_pkg::KIND_INSERT) begin
      if (fill_level < HEAP_DEPTH) fill_level++;
    end else if (fill_level > 0) begin
      fill_level--;
    end
  endtask

  // Drop valid for the gap given by n; scramble the idle payload meanwhile.
  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      in_data  <= '{kind: hpq_pkg::kind_e'($urandom_range(0, 1)), key: $urandom()};
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop offering until every predicted result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // Result side: random stalls, quiet stretches, and one long hold-off once
  // the sender is well into the random part.
  initial begin : result_side
    bit held_long;
    held_long = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held_long && sent_count >= HOLD_AFTER) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        held_long = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat (draw_gap() + 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat (($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                             : $urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int  ins_pct;
    bit  steady;
    in_valid <= 1'b0;
    in_data  <= '0;
    rst_n    <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: extract from an empty heap, key extremes, repeated keys,
    // then pull everything back out and hit empty once more.
    push_op(hpq_pkg::KIND_EXTRACT, 32'hffff_ffff);
    push_op(hpq_pkg::KIND_INSERT,  32'h7fff_ffff);
    push_op(hpq_pkg::KIND_INSERT,  32'h8000_0000);
    push_op(hpq_pkg::KIND_INSERT,  32'h0000_0000);
    push_op(hpq_pkg::KIND_INSERT,  32'hffff_ffff);
    push_op(hpq_pkg::KIND_INSERT,  32'h0000_0001);
    push_op(hpq_pkg::KIND_INSERT,  32'h0000_0005);
    push_op(hpq_pkg::KIND_INSERT,  32'h0000_0005);
    push_op(hpq_pkg::KIND_INSERT,  32'h0000_0005);
    push_op(hpq_pkg::KIND_INSERT,  32'h8000_0000);
    push_op(hpq_pkg::KIND_INSERT,  32'h7fff_ffff);
    repeat (11) push_op(hpq_pkg::KIND_EXTRACT, $urandom());
    push_op(hpq_pkg::KIND_EXTRACT, 32'h0000_0000);
    wait_drained();

    // Random segments; each picks its own insert share so the heap both
    // grows deep and runs dry. Some segments run with no gaps at all.
    for (int seg = 0; seg < 12; seg++) begin
      case ($urandom_range(0, 3))
        0:       ins_pct = 30;
        1:       ins_pct = 50;
        2:       ins_pct = 70;
        default: ins_pct = 90;
      endcase
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 50; i++) begin
        push_op(hpq_pkg::kind_e'($urandom_range(1, 100) > ins_pct), draw_key());
        if (!steady) idle_gap(draw_gap());
      end
      if (seg == 6) wait_drained();
    end

    // Drain to empty and extract once more.
    while (fill_level > 0) begin
      push_op(hpq_pkg::KIND_EXTRACT, $urandom());
      idle_gap(draw_gap());
    end
    push_op(hpq_pkg::KIND_EXTRACT, $urandom());

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
